/* hw/rtl/trajectory_cost_evaluator_unit_defines.svh */
// Assertion macros used by the trajectory cost evaluator top level.
`ifndef TRAJECTORY_COST_EVALUATOR_UNIT_DEFINES_SVH
`define TRAJECTORY_COST_EVALUATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define TCE_ASSERT_IMP(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("tce implication check failed");
// Next-cycle implication check.
`define TCE_ASSERT_NXT(name, clk, rst, a, b) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("tce next-cycle check failed");
`else
`define TCE_ASSERT_IMP(name, clk, rst, a, b)
`define TCE_ASSERT_NXT(name, clk, rst, a, b)
`endif

`endif

/* hw/rtl/tce_pkg.sv */
// Types, constants and helper functions of the trajectory cost evaluator.
package tce_pkg;

  localparam int MAX_STEPS_DEF            = 32;
  localparam int OBSTACLE_TABLE_DEPTH_DEF = 256;
  localparam int FRAC_BITS_DEF            = 10;

  localparam int VAL_W       = 20;
  localparam int COST_W      = 48;
  localparam int OBS_IDX_W   = 12;
  localparam int OBS_ENTRY_W = 23;
  localparam int CFG_IDX_W   = 3;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_POS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_POS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_POS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_VEL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_VEL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_VEL_Z = 3'd5;

  typedef struct packed {
    logic signed [VAL_W-1:0] pos_x;
    logic signed [VAL_W-1:0] pos_y;
    logic signed [VAL_W-1:0] pos_z;
    logic signed [VAL_W-1:0] vel_x;
    logic signed [VAL_W-1:0] vel_y;
    logic signed [VAL_W-1:0] vel_z;
    logic signed [VAL_W-1:0] acc_x;
    logic signed [VAL_W-1:0] acc_y;
    logic signed [VAL_W-1:0] acc_z;
    logic signed [VAL_W-1:0] obstacle_distance;
    logic                    last_step;
  } in_word_t;

  typedef struct packed {
    logic [COST_W-1:0] trajectory_cost;
    logic              collided;
  } out_word_t;

  typedef enum logic [1:0] {
    DIST_FAR,
    DIST_NEAR,
    DIST_HIT
  } dist_kind_t;

  // One classified step as it travels from the front to the back.
  typedef struct packed {
    logic [2:0][VAL_W-1:0] pos;
    logic [2:0][VAL_W-1:0] vel;
    logic [2:0][VAL_W-1:0] acc;
    dist_kind_t            kind;
    logic [OBS_IDX_W-1:0]  idx;
    logic                  last;
  } step_rec_t;

  typedef struct packed {
    logic [2:0][VAL_W-1:0] gpos;
    logic [2:0][VAL_W-1:0] gvel;
  } goal_t;

  // Saturating 48-bit add.
  function automatic logic [COST_W-1:0] sat_add48(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

  // Converts a value with fb fraction bits to Q16 by truncation, saturating.
  function automatic logic [COST_W-1:0] to_q16(input logic [63:0] x,
                                               input int unsigned fb);
    logic [63:0] y;
    if (fb >= 16) begin
      y = x >> (fb - 16);
    end else begin
      y = x << (16 - fb);
    end
    return (y > 64'(COST_MAX)) ? COST_MAX : y[COST_W-1:0];
  endfunction

endpackage

/* hw/rtl/tce_queue.sv */
// Two-entry queue between the front and back parts.
module tce_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] slot [2];
  logic         rd_ptr;
  logic         wr_ptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slot[rd_ptr];

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= wdata;
    end
  end

endmodule

/* hw/rtl/tce_front.sv */
// Front part: accepts trajectory steps and classifies the obstacle distance.
module tce_front #(
  parameter int OBSTACLE_TABLE_DEPTH = tce_pkg::OBSTACLE_TABLE_DEPTH_DEF,
  parameter int FRAC_BITS            = tce_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tce_pkg::in_word_t   item,
  input  logic                push,
  output logic                full,
  output tce_pkg::step_rec_t  q_word,
  output logic                q_push,
  input  logic                q_full
);
  import tce_pkg::*;

  localparam int PROD_W = FRAC_BITS + 13;
  localparam logic signed [VAL_W-1:0] NEAR_LIM = VAL_W'(1 << FRAC_BITS);

  logic                 held;
  step_rec_t            rec;
  step_rec_t            rec_next;
  logic [PROD_W-1:0]    idx_prod;

  assign full   = held && q_full;
  assign q_push = held;
  assign q_word = rec;

  // Table index of a distance in [0, 1).
  assign idx_prod = PROD_W'(item.obstacle_distance[FRAC_BITS-1:0]) *
                    PROD_W'(OBSTACLE_TABLE_DEPTH);

  // Classify the incoming step.
  always_comb begin
    rec_next.pos  = {item.pos_z, item.pos_y, item.pos_x};
    rec_next.vel  = {item.vel_z, item.vel_y, item.vel_x};
    rec_next.acc  = {item.acc_z, item.acc_y, item.acc_x};
    rec_next.last = item.last_step;
    rec_next.idx  = OBS_IDX_W'(idx_prod >> FRAC_BITS);
    if (item.obstacle_distance < 0) begin
      rec_next.kind = DIST_HIT;
    end else if (item.obstacle_distance < NEAR_LIM) begin
      rec_next.kind = DIST_NEAR;
    end else begin
      rec_next.kind = DIST_FAR;
    end
  end

  // One holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (push && !full) begin
      held <= 1'b1;
    end else if (held && !q_full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      rec <= rec_next;
    end
  end

endmodule

/* hw/rtl/tce_back.sv */
// Back part: squared-error sequencer, running sums, final division and result.
module tce_back #(
  parameter int MAX_STEPS            = tce_pkg::MAX_STEPS_DEF,
  parameter int OBSTACLE_TABLE_DEPTH = tce_pkg::OBSTACLE_TABLE_DEPTH_DEF,
  parameter int FRAC_BITS            = tce_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tce_pkg::goal_t      goal,
  input  tce_pkg::step_rec_t  q_word,
  input  logic                q_empty,
  output logic                q_pop,
  output tce_pkg::out_word_t  result,
  output logic                empty,
  input  logic                pop
);
  import tce_pkg::*;

  localparam int TBL_W  = (OBSTACLE_TABLE_DEPTH > 1) ? $clog2(OBSTACLE_TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_STEPS + 1);
  localparam int SQ_W   = 41;
  localparam int ACC_W  = 43;
  localparam int DVD_W  = COST_W + 5;
  localparam int DIV_CW = $clog2(DVD_W);
  localparam logic [3:0] LAST_SQ = 4'd11;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [3:0] {
    B_IDLE, B_LOAD, B_SQ, B_DRAIN, B_UPD, B_FIN1, B_FIN2, B_DIV, B_FIN3
  } bstate_t;

  // Obstacle cost table, built at elaboration.
  logic [OBS_ENTRY_W-1:0] obs_tbl [OBSTACLE_TABLE_DEPTH];

  for (genvar i = 0; i < OBSTACLE_TABLE_DEPTH; i++) begin : g_tbl
    localparam logic [63:0] X  = (64'(5 * i) << 30) / OBSTACLE_TABLE_DEPTH;
    localparam logic [63:0] T  = X >> 6;
    localparam logic [63:0] T2 = (T * T) >> 30;
    localparam logic [63:0] T3 = (T2 * T) >> 30;
    localparam logic [63:0] T4 = (T3 * T) >> 30;
    localparam logic [63:0] V0 = (Q30_ONE + T2 / 2 + T4 / 24) - (T + T3 / 6);
    localparam logic [63:0] V1 = (V0 * V0 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] V2 = (V1 * V1 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] V3 = (V2 * V2 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] V4 = (V3 * V3 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] V5 = (V4 * V4 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] V6 = (V5 * V5 + (64'd1 << 29)) >> 30;
    localparam logic [63:0] DEN = (64'(100 * i) + 64'(OBSTACLE_TABLE_DEPTH)) << 14;
    localparam logic [63:0] ENT = (V6 * 64'd100 * 64'(OBSTACLE_TABLE_DEPTH) + DEN / 2) / DEN;
    assign obs_tbl[i] = ENT[OBS_ENTRY_W-1:0];
  end

  bstate_t                state;
  step_rec_t              cur;
  logic [OBS_ENTRY_W-1:0] entry;
  logic [3:0]             k;
  logic [3:0]             sq_k;
  logic                   sq_vld;
  logic [SQ_W-1:0]        sq;
  logic [ACC_W-1:0]       a_sq;
  logic [ACC_W-1:0]       v_sq;
  logic [ACC_W-1:0]       e_sq;
  logic [ACC_W-1:0]       p_sq;
  logic [2:0][VAL_W-1:0]  prev_acc;
  logic [2:0][VAL_W-1:0]  prev_vel;
  logic                   first;
  logic [COST_W-1:0]      obs_sum;
  logic [COST_W-1:0]      smooth_sum;
  logic [COST_W-1:0]      verr_sum;
  logic [CNT_W-1:0]       step_cnt;
  logic                   coll;
  logic [COST_W-1:0]      total;
  logic [COST_W-1:0]      fin_term;
  logic [DVD_W-1:0]       dvd;
  logic [CNT_W-1:0]       rem;
  logic [DIV_CW-1:0]      div_cnt;
  out_word_t              res;
  logic                   res_valid;

  logic [VAL_W-1:0]        op_a;
  logic [VAL_W-1:0]        op_b;
  logic signed [VAL_W:0]   diff;
  logic signed [2*VAL_W+1:0] prod;
  logic [CNT_W:0]          rem_sh;
  logic [63:0]             smooth_raw;
  logic [63:0]             goal_raw;
  logic [COST_W-1:0]       mean_sat;
  logic [COST_W-1:0]       obs_add;

  assign q_pop  = (state == B_IDLE) && !q_empty;
  assign result = res;
  assign empty  = !res_valid;

  // Operand pair of the current square.
  always_comb begin
    case (k)
      4'd0, 4'd1, 4'd2: begin
        op_a = cur.acc[k[1:0]];
        op_b = prev_acc[k[1:0]];
      end
      4'd3: begin op_a = cur.vel[0]; op_b = prev_vel[0]; end
      4'd4: begin op_a = cur.vel[1]; op_b = prev_vel[1]; end
      4'd5: begin op_a = cur.vel[2]; op_b = prev_vel[2]; end
      4'd6: begin op_a = cur.vel[0]; op_b = goal.gvel[0]; end
      4'd7: begin op_a = cur.vel[1]; op_b = goal.gvel[1]; end
      4'd8: begin op_a = cur.vel[2]; op_b = goal.gvel[2]; end
      4'd9: begin op_a = cur.pos[0]; op_b = goal.gpos[0]; end
      4'd10: begin op_a = cur.pos[1]; op_b = goal.gpos[1]; end
      4'd11: begin op_a = cur.pos[2]; op_b = goal.gpos[2]; end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = $signed({op_a[VAL_W-1], op_a}) - $signed({op_b[VAL_W-1], op_b});
    prod = diff * diff;
  end

  // Weighted terms, divider step and obstacle increment.
  always_comb begin
    smooth_raw = 64'd10 * ({21'd0, a_sq} * 64'd2 + {21'd0, v_sq});
    goal_raw   = 64'd50 * ({21'd0, p_sq} * 64'd2 + {21'd0, e_sq});
    rem_sh     = {rem, dvd[DVD_W-1]};
    mean_sat   = (dvd > DVD_W'(COST_MAX)) ? COST_MAX : dvd[COST_W-1:0];
    obs_add    = COST_W'(entry) * COST_W'(100);
  end

  // Sequencer, sums and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      res_valid  <= 1'b0;
      first      <= 1'b1;
      obs_sum    <= '0;
      smooth_sum <= '0;
      verr_sum   <= '0;
      step_cnt   <= '0;
      coll       <= 1'b0;
      prev_acc   <= '0;
      prev_vel   <= '0;
      sq_vld     <= 1'b0;
    end else begin
      // A popped result frees the register unless a new one loads now.
      if (pop && res_valid && (state != B_FIN3)) begin
        res_valid <= 1'b0;
      end

      // Fold the previous square into its group.
      if (sq_vld) begin
        if (sq_k inside {[4'd0:4'd2]}) begin
          a_sq <= a_sq + ACC_W'(sq);
        end else if (sq_k inside {[4'd3:4'd5]}) begin
          v_sq <= v_sq + ACC_W'(sq);
        end else if (sq_k inside {[4'd6:4'd8]}) begin
          e_sq <= e_sq + ACC_W'(sq);
        end else begin
          p_sq <= p_sq + ACC_W'(sq);
        end
      end

      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur   <= q_word;
            state <= B_LOAD;
          end
        end
        B_LOAD: begin
          entry  <= obs_tbl[cur.idx[TBL_W-1:0]];
          a_sq   <= '0;
          v_sq   <= '0;
          e_sq   <= '0;
          p_sq   <= '0;
          sq_vld <= 1'b0;
          k      <= '0;
          state  <= B_SQ;
        end
        B_SQ: begin
          sq     <= prod[SQ_W-1:0];
          sq_k   <= k;
          sq_vld <= 1'b1;
          k      <= k + 4'd1;
          if (k == LAST_SQ) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          sq_vld <= 1'b0;
          state  <= B_UPD;
        end
        B_UPD: begin
          if (!first) begin
            smooth_sum <= sat_add48(smooth_sum, to_q16(smooth_raw, 2 * FRAC_BITS + 1));
          end
          verr_sum <= sat_add48(verr_sum, to_q16({21'd0, e_sq}, 2 * FRAC_BITS));
          if (cur.kind == DIST_NEAR) begin
            obs_sum <= sat_add48(obs_sum, obs_add);
          end
          if (cur.kind == DIST_HIT) begin
            coll <= 1'b1;
          end
          if (step_cnt < CNT_W'(MAX_STEPS)) begin
            step_cnt <= step_cnt + CNT_W'(1);
          end
          first    <= 1'b0;
          prev_acc <= cur.acc;
          prev_vel <= cur.vel;
          state    <= cur.last ? B_FIN1 : B_IDLE;
        end
        B_FIN1: begin
          total    <= sat_add48(obs_sum, smooth_sum);
          fin_term <= to_q16(goal_raw, 2 * FRAC_BITS + 1);
          dvd      <= DVD_W'({verr_sum, 4'd0}) + DVD_W'({verr_sum, 2'd0});
          rem      <= '0;
          div_cnt  <= '0;
          state    <= B_FIN2;
        end
        B_FIN2: begin
          total <= sat_add48(total, fin_term);
          state <= B_DIV;
        end
        B_DIV: begin
          // Restoring division by the step count, one quotient bit a cycle.
          if (rem_sh >= {1'b0, step_cnt}) begin
            rem <= CNT_W'(rem_sh - {1'b0, step_cnt});
            dvd <= {dvd[DVD_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[CNT_W-1:0];
            dvd <= {dvd[DVD_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + DIV_CW'(1);
          if (div_cnt == DIV_CW'(DVD_W - 1)) begin
            state <= B_FIN3;
          end
        end
        B_FIN3: begin
          if (!res_valid || pop) begin
            res.trajectory_cost <= coll ? COST_MAX : sat_add48(total, mean_sat);
            res.collided        <= coll;
            res_valid           <= 1'b1;
            first      <= 1'b1;
            obs_sum    <= '0;
            smooth_sum <= '0;
            verr_sum   <= '0;
            step_cnt   <= '0;
            coll       <= 1'b0;
            prev_acc   <= '0;
            prev_vel   <= '0;
            state      <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/trajectory_cost_evaluator_unit.sv */
// Trajectory cost evaluator: one trajectory step per word in, one cost per
// trajectory out on the step flagged last. In the back part, a single shared
// squarer works through twelve component differences of a step, one per
// cycle; a last step adds the bit-serial division of twenty times the
// velocity error sum by the step count. A one-word front register and a
// two-word queue let the input keep accepting words while the back part is
// busy. The obstacle cost table is constant logic, so there is no clearing
// pass after reset.
module trajectory_cost_evaluator_unit #(
  parameter int MAX_STEPS            = tce_pkg::MAX_STEPS_DEF,
  parameter int OBSTACLE_TABLE_DEPTH = tce_pkg::OBSTACLE_TABLE_DEPTH_DEF,
  parameter int FRAC_BITS            = tce_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tce_pkg::in_word_t                 item,
  input  logic                              push,
  output logic                              full,
  output tce_pkg::out_word_t                result,
  output logic                              empty,
  input  logic                              pop,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tce_pkg::VAL_W-1:0]         cfg_data
);
  import tce_pkg::*;

  `include "trajectory_cost_evaluator_unit_defines.svh"

  goal_t     goal;
  step_rec_t f_word;
  step_rec_t q_word;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;

  assign cfg_ready = 1'b1;

  // Goal registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      goal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GOAL_POS_X: goal.gpos[0] <= cfg_data;
        REG_GOAL_POS_Y: goal.gpos[1] <= cfg_data;
        REG_GOAL_POS_Z: goal.gpos[2] <= cfg_data;
        REG_GOAL_VEL_X: goal.gvel[0] <= cfg_data;
        REG_GOAL_VEL_Y: goal.gvel[1] <= cfg_data;
        REG_GOAL_VEL_Z: goal.gvel[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tce_front #(
    .OBSTACLE_TABLE_DEPTH(OBSTACLE_TABLE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .item(item),
    .push(push),
    .full(full),
    .q_word(f_word),
    .q_push(q_push),
    .q_full(q_full)
  );

  tce_queue #(
    .W($bits(step_rec_t))
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wdata(f_word),
    .full(q_full),
    .pop(q_pop),
    .rdata(q_word),
    .empty(q_empty)
  );

  tce_back #(
    .MAX_STEPS(MAX_STEPS),
    .OBSTACLE_TABLE_DEPTH(OBSTACLE_TABLE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .goal(goal),
    .q_word(q_word),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .result(result),
    .empty(empty),
    .pop(pop)
  );

  // A collided trajectory always reports the maximum cost.
  `TCE_ASSERT_IMP(a_coll_max, clk, rst, !empty && result.collided, &result.trajectory_cost)
  // The back part never takes a word from an empty queue.
  `TCE_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, !q_empty)
  // A word pushed into the queue is visible on the next cycle.
  `TCE_ASSERT_NXT(a_push_visible, clk, rst, q_push && !q_full, !q_empty)

endmodule

/* dv/tb_trajectory_cost_evaluator_unit.sv */
// Self-checking testbench for the trajectory cost evaluator unit.
`timescale 1ns / 1ps

module tb_trajectory_cost_evaluator_unit;
  import tce_pkg::*;

  localparam int  MAX_STEPS  = MAX_STEPS_DEF;
  localparam int  TBL_DEPTH  = OBSTACLE_TABLE_DEPTH_DEF;
  localparam int  FRAC       = FRAC_BITS_DEF;
  localparam int  DRAIN_WAIT = 120;
  localparam int  CYCLE_CAP  = 600000;
  localparam logic signed [VAL_W-1:0] V_MAX = 20'sh7FFFF;
  localparam logic signed [VAL_W-1:0] V_MIN = 20'sh80000;
  localparam logic signed [VAL_W-1:0] ONE_M = 20'sd1024;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_word_t  item = '0;
  logic      push = 1'b0;
  logic      full;
  out_word_t result;
  logic      empty;
  logic      pop = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_data = '0;

  trajectory_cost_evaluator_unit u_top (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .result(result), .empty(empty), .pop(pop),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow of the goal registers and the per-trajectory state.
  logic signed [VAL_W-1:0] goal_reg [6];
  logic signed [VAL_W-1:0] last_acc [3];
  logic signed [VAL_W-1:0] last_vel [3];
  bit                      first_pending;
  logic [COST_W-1:0]       obs_acc, smooth_acc, vel_err_acc;
  int                      steps_seen;
  bit                      hit_seen;

  out_word_t cost_q[$];
  int        errors = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_cycles = 0;

  function automatic longint unsigned sat48(longint unsigned v);
    return (v > longint'(COST_MAX)) ? longint'(COST_MAX) : v;
  endfunction

  // Obstacle cost table entry: truncated series for exp, squared six times.
  function automatic longint unsigned obstacle_cost(longint unsigned idx);
    longint unsigned x, t, t2, t3, t4, v, den;
    x  = ((5 * idx) << 30) / TBL_DEPTH;
    t  = x >> 6;
    t2 = (t * t) >> 30;
    t3 = (t2 * t) >> 30;
    t4 = (t3 * t) >> 30;
    v  = ((64'd1 << 30) + t2 / 2 + t4 / 24) - (t + t3 / 6);
    for (int k = 0; k < 6; k++) v = (v * v + (64'd1 << 29)) >> 30;
    den = (100 * idx + TBL_DEPTH) << 14;
    return (v * 100 * TBL_DEPTH + den / 2) / den;
  endfunction

  function automatic longint unsigned sq_dist(longint a0, longint a1, longint a2,
                                              longint b0, longint b1, longint b2);
    return (a0 - b0) * (a0 - b0) + (a1 - b1) * (a1 - b1) + (a2 - b2) * (a2 - b2);
  endfunction

  task automatic clear_traj();
    for (int k = 0; k < 3; k++) begin
      last_acc[k] = '0;
      last_vel[k] = '0;
    end
    first_pending = 1'b1;
    obs_acc = '0;
    smooth_acc = '0;
    vel_err_acc = '0;
    steps_seen = 0;
    hit_seen = 1'b0;
  endtask

  // Advances the shadow state by one step; returns the cost on a last step.
  task automatic cost_step(input in_word_t w, output bit has_cost, output out_word_t c);
    longint d, term, total, mean;
    d = w.obstacle_distance;
    has_cost = 1'b0;
    c = '0;
    if (d < 0) begin
      hit_seen = 1'b1;
    end else if (d < (1 << FRAC)) begin
      obs_acc = COST_W'(sat48(obs_acc + 100 * obstacle_cost((d * TBL_DEPTH) >> FRAC)));
    end
    if (!first_pending) begin
      term = 2 * sq_dist(w.acc_x, w.acc_y, w.acc_z, last_acc[0], last_acc[1], last_acc[2])
           + sq_dist(w.vel_x, w.vel_y, w.vel_z, last_vel[0], last_vel[1], last_vel[2]);
      smooth_acc = COST_W'(sat48(smooth_acc + sat48((10 * term) >> (2 * FRAC + 1 - 16))));
    end
    first_pending = 1'b0;
    last_acc = '{w.acc_x, w.acc_y, w.acc_z};
    last_vel = '{w.vel_x, w.vel_y, w.vel_z};
    term = sq_dist(w.vel_x, w.vel_y, w.vel_z, goal_reg[3], goal_reg[4], goal_reg[5]);
    vel_err_acc = COST_W'(sat48(vel_err_acc + sat48(term >> (2 * FRAC - 16))));
    if (steps_seen < MAX_STEPS) steps_seen++;
    if (w.last_step) begin
      has_cost = 1'b1;
      if (hit_seen) begin
        c.trajectory_cost = COST_MAX;
        c.collided = 1'b1;
      end else begin
        term = 2 * sq_dist(w.pos_x, w.pos_y, w.pos_z, goal_reg[0], goal_reg[1], goal_reg[2])
             + sq_dist(w.vel_x, w.vel_y, w.vel_z, goal_reg[3], goal_reg[4], goal_reg[5]);
        total = sat48(obs_acc + smooth_acc);
        total = sat48(total + sat48((50 * term) >> (2 * FRAC + 1 - 16)));
        mean = (20 * longint'(vel_err_acc)) / steps_seen;
        total = sat48(total + sat48(mean));
        c.trajectory_cost = total[COST_W-1:0];
        c.collided = 1'b0;
      end
      clear_traj();
    end
  endtask

  // Sends one step word; typed-in expectations override the predicted cost.
  task automatic send_step(input in_word_t w, input bit typed, input out_word_t typed_cost);
    bit        has_cost;
    out_word_t c;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= w;
    push <= 1'b1;
    do @(posedge clk); while (full);
    cost_step(w, has_cost, c);
    if (has_cost) cost_q = {cost_q, (typed ? typed_cost : c)};
  endtask

  task automatic write_goal(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    goal_reg[idx] = v;
  endtask

  // Stops sending and waits until every expected cost has been popped.
  task automatic drain();
    push <= 1'b0;
    while (cost_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] rand_val(int near_pct);
    int r;
    r = $urandom_range(99);
    if (r < near_pct) return VAL_W'($urandom_range(4095)) - 20'sd2048;
    if (r < near_pct + 8) return $urandom_range(1) ? V_MAX : V_MIN;
    return VAL_W'($urandom);
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_dist();
    int r;
    r = $urandom_range(99);
    if (r < 55) return VAL_W'($urandom_range(1023));
    if (r < 60) return -VAL_W'($urandom_range(1, 3000));
    if (r < 70) return ONE_M;
    return VAL_W'($urandom);
  endfunction

  function automatic in_word_t rand_step(bit is_last);
    in_word_t w;
    w.pos_x = rand_val(60); w.pos_y = rand_val(60); w.pos_z = rand_val(60);
    w.vel_x = rand_val(60); w.vel_y = rand_val(60); w.vel_z = rand_val(60);
    w.acc_x = rand_val(60); w.acc_y = rand_val(60); w.acc_z = rand_val(60);
    w.obstacle_distance = rand_dist();
    w.last_step = is_last;
    return w;
  endfunction

  // One whole trajectory; mostly short, sometimes past the step limit.
  task automatic send_traj(output int n);
    out_word_t none;
    none = '0;
    n = ($urandom_range(99) < 8) ? $urandom_range(MAX_STEPS + 1, MAX_STEPS + 8)
                                 : $urandom_range(1, 6);
    for (int s = 0; s < n; s++) send_step(rand_step(s == n - 1), 1'b0, none);
  endtask

  // Receiver side: compare each popped word and pick the next pop level.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (cost_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: cost %h collided %b",
                                     result.trajectory_cost, result.collided);
        end else begin
          if (result !== cost_q[0]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected cost %h collided %b, got cost %h collided %b",
                       cost_q[0].trajectory_cost, cost_q[0].collided,
                       result.trajectory_cost, result.collided);
          end
          void'(cost_q.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t cost;
  } row_t;

  row_t rows[$];

  // Appends one row to the directed table.
  task automatic add_row(input in_word_t w, input bit typed, input out_word_t cost);
    rows = {rows, row_t'{w, typed, cost}};
  endtask

  function automatic in_word_t mk(logic signed [VAL_W-1:0] p, logic signed [VAL_W-1:0] v,
                                  logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] d,
                                  bit is_last);
    in_word_t w;
    w = '{p, p, p, v, v, v, a, a, a, d, is_last};
    return w;
  endfunction

  initial begin
    out_word_t hit, zero_cost;
    int n;
    hit = '{COST_MAX, 1'b1};
    zero_cost = '0;
    for (int k = 0; k < 6; k++) goal_reg[k] = '0;
    clear_traj();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed steps with the goal at the origin.
    add_row(mk(0, 0, 0, ONE_M, 1), 1, zero_cost);   // at goal, far from obstacles
    add_row(mk(0, 0, 0, V_MAX, 1), 1, zero_cost);
    add_row(mk(0, 0, 0, 0, 1), 0, zero_cost);       // touching an obstacle
    add_row(mk(0, 0, 0, ONE_M - 1, 1), 0, zero_cost);
    add_row(mk(0, 0, 0, -1, 1), 1, hit);
    add_row(mk(V_MAX, V_MAX, V_MAX, V_MIN, 1), 1, hit);
    add_row(mk(V_MAX, V_MAX, V_MAX, 512, 0), 0, zero_cost);
    add_row(mk(V_MIN, V_MIN, V_MIN, 100, 1), 0, zero_cost); // saturating terms
    add_row(mk(5, 3, 1, 200, 0), 0, zero_cost);
    add_row(mk(6, 4, 2, 300, 0), 0, zero_cost);
    add_row(mk(7, 5, 3, 400, 1), 0, zero_cost);
    add_row(mk(1, 1, 1, 50, 0), 0, zero_cost);   // collision mid-trajectory
    add_row(mk(1, 1, 1, -300, 0), 0, zero_cost);
    add_row(mk(1, 1, 1, 50, 1), 1, hit);
    foreach (rows[i]) send_step(rows[i].w, rows[i].typed, rows[i].cost);
    // Over the step limit: the mean divides by the limit.
    for (int s = 0; s < MAX_STEPS + 3; s++)
      send_step(mk(s, s * 3, -s, 700, s == MAX_STEPS + 2), 0, zero_cost);
    drain();

    // Three phases of random trajectories with different goals and idling.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          write_goal(REG_GOAL_POS_X, V_MIN); write_goal(REG_GOAL_POS_Y, V_MAX);
          write_goal(REG_GOAL_POS_Z, V_MIN); write_goal(REG_GOAL_VEL_X, V_MAX);
          write_goal(REG_GOAL_VEL_Y, V_MIN); write_goal(REG_GOAL_VEL_Z, V_MAX);
          send_idle_pct = 21; recv_idle_pct = 84;
        end
        1: begin
          write_goal(REG_GOAL_POS_X, VAL_W'($urandom_range(4095)) - 20'sd2048);
          write_goal(REG_GOAL_POS_Y, VAL_W'($urandom));
          write_goal(REG_GOAL_POS_Z, VAL_W'($urandom_range(4095)) - 20'sd2048);
          write_goal(REG_GOAL_VEL_X, VAL_W'($urandom_range(4095)) - 20'sd2048);
          write_goal(REG_GOAL_VEL_Y, VAL_W'($urandom_range(4095)) - 20'sd2048);
          write_goal(REG_GOAL_VEL_Z, VAL_W'($urandom));
          send_idle_pct = 84; recv_idle_pct = 21;
        end
        default: begin
          write_goal(REG_GOAL_POS_X, '0); write_goal(REG_GOAL_POS_Y, '0);
          write_goal(REG_GOAL_POS_Z, '0); write_goal(REG_GOAL_VEL_X, '0);
          write_goal(REG_GOAL_VEL_Y, '0); write_goal(REG_GOAL_VEL_Z, '0);
          send_idle_pct = 0; recv_idle_pct = 0;
        end
      endcase
      // Hold the receiver off while single-step trajectories pile up.
      if (ph == 0) begin
        hold_cycles = 600;
        for (int s = 0; s < 25; s++) send_step(rand_step(1), 0, zero_cost);
      end
      n = 0;
      while (n < 220) begin
        int len;
        send_traj(len);
        n += len;
      end
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
